// ===== rtl/core/pva_pkg.sv =====
// Shared types and constants for the scroll address counter.
// No dependencies; imported by pva_next_addr and ppu_vram_address_counter.
`timescale 1ns / 1ps

package pva_pkg;

  localparam int unsigned CoarseW = 5;
  localparam int unsigned FineW   = 3;
  localparam int unsigned AddrW   = 15;

  // coarse Y row at which the vertical nametable bit flips
  localparam logic [CoarseW-1:0] CoarseYLastRow = 5'd29;
  localparam logic [AddrW-1:0]   IncByOne       = 15'd1;
  localparam logic [AddrW-1:0]   IncByRow       = 15'd32;

  // field order follows the packed address, fine Y in the top bits
  typedef struct packed {
    logic [FineW-1:0]   fine_v;
    logic               nt_v;
    logic               nt_h;
    logic [CoarseW-1:0] coarse_v;
    logic [CoarseW-1:0] coarse_h;
  } scroll_addr_t;

  typedef struct packed {
    logic load_h;
    logic load_v;
    logic step_h;
    logic step_v;
    logic blank;
    logic inc_by_32;
  } scroll_ctrl_t;

endpackage

// ===== rtl/core/pva_next_addr.sv =====
// Next-value logic of the scroll address: tile walk while rendering,
// linear count during blanking, field loads from the temporary address.
// Depends on pva_pkg.
`timescale 1ns / 1ps

module pva_next_addr
  import pva_pkg::*;
(
  input  scroll_ctrl_t ctrl_i,
  input  scroll_addr_t cur_i,
  input  scroll_addr_t tmp_i,
  output scroll_addr_t next_o
);

  logic [AddrW-1:0]   lin_sum;
  logic [CoarseW-1:0] coarse_h_inc;
  logic [CoarseW-1:0] coarse_v_inc;
  logic [FineW-1:0]   fine_v_inc;
  logic               coarse_h_wrap;
  logic               fine_v_wrap;

  assign lin_sum       = AddrW'(cur_i) + (ctrl_i.inc_by_32 ? IncByRow : IncByOne);
  assign coarse_h_inc  = cur_i.coarse_h + CoarseW'(1);
  assign coarse_v_inc  = cur_i.coarse_v + CoarseW'(1);
  assign fine_v_inc    = cur_i.fine_v + FineW'(1);
  assign coarse_h_wrap = &cur_i.coarse_h;
  assign fine_v_wrap   = &cur_i.fine_v;

  always_comb begin
    next_o = cur_i;
    if (ctrl_i.blank && (ctrl_i.step_h || ctrl_i.step_v)) begin
      next_o = scroll_addr_t'(lin_sum);
    end else begin
      // horizontal group: step wins over load
      if (ctrl_i.step_h) begin
        next_o.coarse_h = coarse_h_inc;
        if (coarse_h_wrap) begin
          next_o.nt_h = ~cur_i.nt_h;
        end
      end else if (ctrl_i.load_h) begin
        next_o.coarse_h = tmp_i.coarse_h;
        next_o.nt_h     = tmp_i.nt_h;
      end
      // vertical group
      if (ctrl_i.step_v) begin
        next_o.fine_v = fine_v_inc;
        if (fine_v_wrap) begin
          if (cur_i.coarse_v == CoarseYLastRow) begin
            next_o.coarse_v = '0;
            next_o.nt_v     = ~cur_i.nt_v;
          end else begin
            // 31 rolls over to 0 on its own without a flip
            next_o.coarse_v = coarse_v_inc;
          end
        end
      end else if (ctrl_i.load_v) begin
        next_o.fine_v   = tmp_i.fine_v;
        next_o.coarse_v = tmp_i.coarse_v;
        next_o.nt_v     = tmp_i.nt_v;
      end
    end
  end

endmodule

// ===== rtl/core/ppu_vram_address_counter.sv =====
// Top level of the scroll address counter.
// Depends on pva_pkg and pva_next_addr.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one pixel clock's strobes
//   and the temporary address fields. Output channel (out_valid_o /
//   out_stall_i) carries the address after that pixel clock.
//   A transfer happens on a rising edge with valid high and stall low.
// Result and throughput:
//   The result comes from the address register itself, in the cycle after
//   the input transfer. One item per cycle is sustained while out_stall_i is
//   low; the next-value logic is a single pass of a 15-bit add and increments.
// Reset:
//   rst_ni clears all address fields to zero and empties the output.
// Stall:
//   While a result waits under out_stall_i the input is stalled and the
//   address holds; a result taken in the same cycle frees the slot, so a new
//   item can be accepted on that edge.
//
module ppu_vram_address_counter
  import pva_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               load_horiz_i,
  input  logic               load_vert_i,
  input  logic               step_horiz_i,
  input  logic               step_vert_i,
  input  logic               blank_i,
  input  logic               inc_by_32_i,
  input  logic [CoarseW-1:0] new_coarse_h_i,
  input  logic [CoarseW-1:0] new_coarse_v_i,
  input  logic [FineW-1:0]   new_fine_v_i,
  input  logic               new_nt_h_i,
  input  logic               new_nt_v_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CoarseW-1:0] coarse_h_o,
  output logic [CoarseW-1:0] coarse_v_o,
  output logic [FineW-1:0]   fine_v_o,
  output logic               nt_h_o,
  output logic               nt_v_o
);

  scroll_ctrl_t ctrl;
  scroll_addr_t tmp_addr;
  scroll_addr_t addr_q, addr_d;
  logic         out_valid_q, out_valid_d;
  logic         in_xfer;

  assign ctrl = '{
    load_h:    load_horiz_i,
    load_v:    load_vert_i,
    step_h:    step_horiz_i,
    step_v:    step_vert_i,
    blank:     blank_i,
    inc_by_32: inc_by_32_i
  };

  assign tmp_addr = '{
    fine_v:   new_fine_v_i,
    nt_v:     new_nt_v_i,
    nt_h:     new_nt_h_i,
    coarse_v: new_coarse_v_i,
    coarse_h: new_coarse_h_i
  };

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  pva_next_addr u_next (
    .ctrl_i (ctrl),
    .cur_i  (addr_q),
    .tmp_i  (tmp_addr),
    .next_o (addr_d)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      // drop the result once it has been taken
      out_valid_d = 1'b0;
    end
  end

  // the address is both the counter state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        addr_q <= addr_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign coarse_h_o  = addr_q.coarse_h;
  assign coarse_v_o  = addr_q.coarse_v;
  assign fine_v_o    = addr_q.fine_v;
  assign nt_h_o      = addr_q.nt_h;
  assign nt_v_o      = addr_q.nt_v;

endmodule
